// ===== hdl/ndu_pkg.sv =====
package ndu_pkg;

  localparam int CHANNELS   = 64;
  localparam int MAX_ORDER  = 8;
  localparam int CH_W       = $clog2(CHANNELS);
  localparam int LEVEL_W    = $clog2(MAX_ORDER);
  localparam int CNT_W      = LEVEL_W + 1;
  localparam int HIST_DEPTH = CHANNELS * MAX_ORDER;
  localparam int HADDR_W    = CH_W + LEVEL_W;
  localparam int SAMPLE_W   = 24;
  localparam int PERIOD_W   = 23;
  localparam int ORDER_W    = 4;
  localparam int VAL_W      = 32;
  localparam int CFG_IDX_W  = 2;

  typedef logic [CH_W-1:0]            ch_t;
  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [VAL_W-1:0]    val_t;
  typedef logic [PERIOD_W-1:0]        period_t;
  typedef logic [ORDER_W-1:0]         order_t;
  typedef logic [CNT_W-1:0]           cnt_t;
  typedef logic [CFG_IDX_W-1:0]       cfg_idx_t;

  localparam cfg_idx_t CFG_DIFF_ORDER    = 2'd0;
  localparam cfg_idx_t CFG_UNWRAP_PERIOD = 2'd1;
  localparam cfg_idx_t CFG_SCALE         = 2'd2;

  localparam logic [VAL_W-1:0] SCALE_RESET = 32'h0001_0000;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RD,
    ST_DIFF,
    ST_DIVA,
    ST_DIVB,
    ST_WRAP,
    ST_MUL,
    ST_RND,
    ST_WRD,
    ST_WUP,
    ST_FIN
  } state_t;

endpackage

// ===== hdl/ndu_if.sv =====
interface ndu_in_if import ndu_pkg::*; ();
  logic    valid;
  logic    ready;
  ch_t     channel_index;
  sample_t sample_value;
  logic    start_run;

  modport source (output valid, channel_index, sample_value, start_run, input ready);
  modport sink (input valid, channel_index, sample_value, start_run, output ready);
endinterface

interface ndu_out_if import ndu_pkg::*; ();
  logic valid;
  logic ready;
  ch_t  result_channel;
  val_t difference_value;

  modport source (output valid, result_channel, difference_value, input ready);
  modport sink (input valid, result_channel, difference_value, output ready);
endinterface

interface ndu_cfg_if import ndu_pkg::*; ();
  logic             valid;
  logic             ready;
  cfg_idx_t         index;
  logic [VAL_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== hdl/nth_order_difference_unwrap_top.sv =====
// Channel   Dir  Beat
// in_ch     in   channel_index, sample_value, start_run
// out_ch    out  result_channel, difference_value
// cfg       in   index, data (0 order, 1 unwrap period, 2 scale)
//
// Per item: order 0 goes straight to the output; for order N >= 1 each level reads
// history, differences, multiplies and rounds, plus two remainders and a wrap step at
// level 1 when the unwrap period is nonzero; one multiplier and one remainder unit
// are reused for every level. After reset a pass zeroes all 512 history RAM entries
// while in_ch is held not ready. A finished beat waits in the output register; a new
// item is taken meanwhile and stalls at its end until that register frees.
module nth_order_difference_unwrap_top import ndu_pkg::*; (
  input logic    clk,
  input logic    rst,
  ndu_in_if.sink    in_ch,
  ndu_out_if.source out_ch,
  ndu_cfg_if.sink   cfg
);

  state_t state, state_next;

  order_t              diff_order;
  period_t             unwrap_period;
  logic [VAL_W-1:0]    scale_per_order;

  logic [HADDR_W-1:0]  clr_cnt;
  ch_t                 ch;
  ch_t                 ch_in;
  cnt_t                n;
  cnt_t                k;
  val_t                x;
  val_t                d;
  logic                neg;
  logic [63:0]         prod;
  sample_t             ra;

  val_t                hist_mem [HIST_DEPTH];
  val_t                hist_rd;
  logic                hist_we;
  logic                hist_re;
  logic [HADDR_W-1:0]  hist_wa;
  logic [HADDR_W-1:0]  hist_ra;
  val_t                hist_wd;

  cnt_t                warm_mem [CHANNELS];
  cnt_t                warm_rd;
  logic [CHANNELS-1:0] warm_vld;
  logic                warm_we;
  cnt_t                warm_cnt;

  logic                div_start;
  sample_t             div_a;
  logic                div_done;
  sample_t             div_rem;

  logic                accept;
  logic                unwrap_now;
  logic                out_load;
  logic [VAL_W:0]      diff33;
  val_t                diff_sat;
  logic signed [SAMPLE_W:0]   wd;
  logic signed [SAMPLE_W+1:0] wd2;
  logic signed [SAMPLE_W+1:0] wp;
  val_t                wrap_d;
  logic [63:0]         rsum;
  logic [47:0]         rmag;
  val_t                scaled;

  assign cfg.ready = 1'b1;
  assign accept = in_ch.valid && in_ch.ready;
  assign unwrap_now = (k == '0) && (unwrap_period != '0);
  assign ch_in = in_ch.channel_index[CH_W-1:0];
  assign warm_cnt = warm_vld[ch] ? warm_rd : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      diff_order      <= '0;
      unwrap_period   <= '0;
      scale_per_order <= SCALE_RESET;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.index)
        CFG_DIFF_ORDER:    diff_order <= cfg.data[ORDER_W-1:0];
        CFG_UNWRAP_PERIOD: unwrap_period <= cfg.data[PERIOD_W-1:0];
        CFG_SCALE:         scale_per_order <= cfg.data;
        default: ;
      endcase
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: if (clr_cnt == HADDR_W'(HIST_DEPTH - 1)) state_next = ST_IDLE;
      ST_IDLE: begin
        if (accept) begin
          state_next = (diff_order == '0) ? ST_FIN : ST_RD;
        end
      end
      ST_RD:   state_next = ST_DIFF;
      ST_DIFF: state_next = unwrap_now ? ST_DIVA : ST_MUL;
      ST_DIVA: if (div_done) state_next = ST_DIVB;
      ST_DIVB: if (div_done) state_next = ST_WRAP;
      ST_WRAP: state_next = ST_MUL;
      ST_MUL:  state_next = ST_RND;
      ST_RND:  state_next = (k + 1'b1 < n) ? ST_RD : ST_WRD;
      ST_WRD:  state_next = ST_WUP;
      ST_WUP:  state_next = ST_FIN;
      ST_FIN:  if (out_load) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ch.ready = 1'b0;
    hist_we     = 1'b0;
    hist_re     = 1'b0;
    hist_wa     = {ch, k[LEVEL_W-1:0]};
    hist_wd     = x;
    warm_we     = 1'b0;
    div_start   = 1'b0;
    div_a       = x[SAMPLE_W-1:0];
    out_load    = 1'b0;
    case (state)
      ST_CLEAR: begin
        hist_we = 1'b1;
        hist_wa = clr_cnt;
        hist_wd = '0;
      end
      ST_IDLE: in_ch.ready = 1'b1;
      ST_RD:   hist_re = 1'b1;
      ST_DIFF: div_start = unwrap_now;
      ST_DIVA: begin
        div_start = div_done;
        div_a     = hist_rd[SAMPLE_W-1:0];
      end
      ST_RND:  hist_we = 1'b1;
      ST_WUP:  warm_we = (warm_cnt < cnt_t'(MAX_ORDER));
      ST_FIN:  out_load = !out_ch.valid || out_ch.ready;
      default: ;
    endcase
  end

  assign hist_ra = {ch, k[LEVEL_W-1:0]};

  always_ff @(posedge clk) begin
    if (hist_we) hist_mem[hist_wa] <= hist_wd;
    if (hist_re) hist_rd <= hist_mem[hist_ra];
  end

  always_ff @(posedge clk) begin
    if (warm_we) warm_mem[ch] <= warm_cnt + 1'b1;
    if (state == ST_WRD) warm_rd <= warm_mem[ch];
  end

  ndu_rem u_rem (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (div_a),
    .divisor   (unwrap_period),
    .done      (div_done),
    .remainder (div_rem)
  );

  // plain difference, saturated
  always_comb begin
    diff33 = {x[VAL_W-1], x} - {hist_rd[VAL_W-1], hist_rd};
    if (diff33[VAL_W] != diff33[VAL_W-1]) begin
      diff_sat = diff33[VAL_W] ? {1'b1, {(VAL_W-1){1'b0}}} : {1'b0, {(VAL_W-1){1'b1}}};
    end else begin
      diff_sat = diff33[VAL_W-1:0];
    end
  end

  // wrap into half a period
  always_comb begin
    wd  = (SAMPLE_W+1)'(ra) - (SAMPLE_W+1)'(div_rem);
    wd2 = {wd, 1'b0};
    wp  = {3'b000, unwrap_period};
    if (wd2 < -wp) begin
      wrap_d = VAL_W'(wd) + VAL_W'(wp);
    end else if (wd2 > wp) begin
      wrap_d = VAL_W'(wd) - VAL_W'(wp);
    end else begin
      wrap_d = VAL_W'(wd);
    end
  end

  // round half away from zero, saturate
  always_comb begin
    rsum = prod + 64'd32768;
    rmag = rsum[63:16];
    if (neg) begin
      scaled = (rmag > 48'h0000_8000_0000) ? {1'b1, {(VAL_W-1){1'b0}}}
                                           : val_t'(-rmag[VAL_W-1:0]);
    end else begin
      scaled = (rmag > 48'h0000_7FFF_FFFF) ? {1'b0, {(VAL_W-1){1'b1}}}
                                           : val_t'(rmag[VAL_W-1:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_CLEAR;
      clr_cnt <= '0;
      warm_vld <= '0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) clr_cnt <= clr_cnt + 1'b1;
      if (accept && in_ch.start_run) warm_vld <= '0;
      if (warm_we) warm_vld[ch] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (accept) begin
          ch <= ch_in;
          x  <= VAL_W'(in_ch.sample_value);
          k  <= '0;
          n  <= (diff_order > ORDER_W'(MAX_ORDER)) ? cnt_t'(MAX_ORDER) : cnt_t'(diff_order);
        end
      end
      ST_DIFF: d <= diff_sat;
      ST_DIVA: if (div_done) ra <= div_rem;
      ST_WRAP: d <= wrap_d;
      ST_MUL: begin
        neg  <= d[VAL_W-1];
        // magnitude is zero-extended so the most negative difference stays 2^31
        prod <= {32'b0, (d[VAL_W-1] ? VAL_W'(-d) : VAL_W'(d))} * {32'b0, scale_per_order};
      end
      ST_RND: begin
        x <= scaled;
        k <= k + 1'b1;
      end
      ST_WUP: if (warm_cnt < n) x <= '0;
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_ch.valid <= 1'b0;
    end else if (out_load) begin
      out_ch.valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_ch.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_ch.result_channel   <= ch;
      out_ch.difference_value <= x;
    end
  end

endmodule

// ===== hdl/ndu_rem.sv =====
module ndu_rem import ndu_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  input  sample_t dividend,
  input  period_t divisor,
  output logic    done,
  output sample_t remainder
);

  localparam int STEP_W = $clog2(SAMPLE_W);

  logic                busy;
  logic [STEP_W-1:0]   step;
  logic [SAMPLE_W-1:0] mag;
  logic [SAMPLE_W-1:0] rem;
  logic                neg;
  logic [SAMPLE_W-1:0] trial;
  logic [SAMPLE_W-1:0] rem_next;

  // restoring remainder, one dividend bit per cycle
  always_comb begin
    trial = {rem[SAMPLE_W-2:0], mag[SAMPLE_W-1]};
    if (trial >= {1'b0, divisor}) begin
      rem_next = trial - {1'b0, divisor};
    end else begin
      rem_next = trial;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + 1'b1;
        if (step == STEP_W'(SAMPLE_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      neg <= dividend[SAMPLE_W-1];
      mag <= dividend[SAMPLE_W-1] ? SAMPLE_W'(-dividend) : SAMPLE_W'(dividend);
      rem <= '0;
    end else if (busy) begin
      mag <= {mag[SAMPLE_W-2:0], 1'b0};
      rem <= rem_next;
    end
  end

  assign remainder = neg ? sample_t'(-rem) : sample_t'(rem);

endmodule

// ===== dv/nth_order_difference_unwrap_top_tb.sv =====
`timescale 1ns / 100ps

module nth_order_difference_unwrap_top_tb;
  import ndu_pkg::*;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int LONG_HOLD      = 700;
  localparam int TAIL_CYCLES    = 200;
  localparam int SAMPLE_MAX     = 8388607;
  localparam int SAMPLE_MIN     = -8388608;

  typedef struct packed {
    ch_t     ch;
    sample_t s;
    logic    start;
  } sample_beat_t;

  typedef struct packed {
    ch_t  ch;
    val_t diff;
  } diff_beat_t;

  logic clk;
  logic rst;

  ndu_in_if  in_ch ();
  ndu_out_if out_ch ();
  ndu_cfg_if cfg ();

  nth_order_difference_unwrap_top u_top (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg    (cfg)
  );

  // model state
  order_t           order_now;
  period_t          period_now;
  logic [VAL_W-1:0] scale_now;
  val_t             level_mem [CHANNELS][MAX_ORDER];
  int unsigned      warm_cnt [CHANNELS];

  sample_beat_t sample_q [$];
  diff_beat_t   diff_q [$];

  int mismatch_count;
  int results_seen;
  int src_idle_pct;
  int snk_idle_pct;
  int src_gap;
  int snk_gap;
  int long_hold_left;
  bit long_hold_done;
  int quiet_cycles;
  sample_beat_t next_beat;
  diff_beat_t   want;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic val_t sat_val(longint v);
    if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
    if (v < -64'sd2147483648) return 32'sh8000_0000;
    return val_t'(v);
  endfunction

  function automatic val_t scaled(val_t d);
    longint          sd;
    longint unsigned mag;
    longint unsigned prod;
    bit              neg;
    sd   = d;
    neg  = (sd < 0);
    mag  = neg ? -sd : sd;
    prod = (mag * scale_now + 64'd32768) >> 16;
    sd   = prod;
    return sat_val(neg ? -sd : sd);
  endfunction

  function automatic val_t level_step(val_t cur, val_t prev, bit unwrap);
    longint d;
    longint p;
    if (unwrap && period_now != '0) begin
      p = period_now;
      d = (longint'(cur) % p) - (longint'(prev) % p);
      if (2 * d < -p) d = d + p;
      else if (2 * d > p) d = d - p;
    end else begin
      d = longint'(cur) - longint'(prev);
    end
    return sat_val(d);
  endfunction

  function automatic val_t predict_difference(ch_t ch, sample_t s, logic start);
    int unsigned n;
    val_t        x;
    val_t        d;
    n = (order_now > MAX_ORDER) ? MAX_ORDER : order_now;
    if (start) begin
      foreach (warm_cnt[i]) warm_cnt[i] = 0;
    end
    x = s;
    for (int k = 0; k < n; k++) begin
      d = level_step(x, level_mem[ch][k], k == 0);
      level_mem[ch][k] = x;
      x = scaled(d);
    end
    if (n != 0) begin
      if (warm_cnt[ch] < n) x = '0;
      if (warm_cnt[ch] < MAX_ORDER) warm_cnt[ch]++;
    end
    return x;
  endfunction

  task automatic push_sample(int ch, int v, bit start);
    sample_beat_t b;
    b.ch    = ch_t'(ch);
    b.s     = sample_t'(v);
    b.start = start;
    sample_q.push_back(b);
  endtask

  // channel-local random walks on up to four channels so warm-up completes, or random samples on any channel
  task automatic queue_random_run(int count);
    ch_t pool [4];
    int  walk [4];
    int  pool_n;
    int  step;
    int  j;
    int  v;
    bit  start;
    pool_n = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 4);
    foreach (pool[i]) begin
      pool[i] = ch_t'($urandom);
      walk[i] = int'($urandom_range(0, 16777215)) + SAMPLE_MIN;
    end
    case ($urandom_range(0, 3))
      0:       step = 3;
      1:       step = 300;
      2:       step = 70000;
      default: step = SAMPLE_MAX;
    endcase
    for (int i = 0; i < count; i++) begin
      start = ($urandom_range(0, 99) == 0) || (i == 0 && $urandom_range(0, 1) == 1);
      if (pool_n == 0) begin
        push_sample($urandom_range(0, CHANNELS - 1),
                    int'($urandom_range(0, 16777215)) + SAMPLE_MIN, start);
      end else begin
        j = $urandom_range(0, pool_n - 1);
        case ($urandom_range(0, 31))
          0:       v = int'($urandom_range(0, 16777215)) + SAMPLE_MIN;
          1:       v = $urandom_range(0, 1) ? SAMPLE_MAX : SAMPLE_MIN;
          default: v = walk[j] + int'($urandom_range(0, 2 * step)) - step;
        endcase
        if (v > SAMPLE_MAX) v = SAMPLE_MAX;
        if (v < SAMPLE_MIN) v = SAMPLE_MIN;
        walk[j] = v;
        push_sample(pool[j], v, start);
      end
    end
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [VAL_W-1:0] value);
    @(posedge clk);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= value;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    case (idx)
      CFG_DIFF_ORDER:    order_now  = value[ORDER_W-1:0];
      CFG_UNWRAP_PERIOD: period_now = value[PERIOD_W-1:0];
      CFG_SCALE:         scale_now  = value;
      default: ;
    endcase
    cfg.valid <= 1'b0;
  endtask

  task automatic wait_drained();
    @(posedge clk);
    while (sample_q.size() != 0 || in_ch.valid || diff_q.size() != 0) @(posedge clk);
  endtask

  // input driver
  always @(posedge clk) begin
    if (rst) begin
      in_ch.valid <= 1'b0;
      src_gap = 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        diff_q.push_back('{ch: in_ch.channel_index,
                           diff: predict_difference(in_ch.channel_index,
                                                    in_ch.sample_value,
                                                    in_ch.start_run)});
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (src_gap == 0 && sample_q.size() != 0 && $urandom_range(0, 99) < src_idle_pct)
          src_gap = $urandom_range(1, 18);
        if (src_gap != 0 || sample_q.size() == 0) begin
          if (src_gap != 0) src_gap--;
          in_ch.valid <= 1'b0;
        end else begin
          next_beat = sample_q.pop_front();
          in_ch.valid         <= 1'b1;
          in_ch.channel_index <= next_beat.ch;
          in_ch.sample_value  <= next_beat.s;
          in_ch.start_run     <= next_beat.start;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
      snk_gap = 0;
      long_hold_left = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        results_seen++;
        if (diff_q.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("%0t: unexpected beat ch=%0d diff=%0d", $realtime,
                     out_ch.result_channel, out_ch.difference_value);
        end else begin
          want = diff_q.pop_front();
          if (want.ch !== out_ch.result_channel || want.diff !== out_ch.difference_value) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("%0t: mismatch exp ch=%0d diff=%0d, got ch=%0d diff=%0d", $realtime,
                       want.ch, want.diff, out_ch.result_channel, out_ch.difference_value);
          end
        end
      end
      if (!long_hold_done && results_seen >= 300 && sample_q.size() > 20) begin
        long_hold_left = LONG_HOLD;
        long_hold_done = 1'b1;
      end
      if (long_hold_left != 0) begin
        long_hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        if (snk_gap == 0 && $urandom_range(0, 99) < snk_idle_pct)
          snk_gap = $urandom_range(1, 18);
        if (snk_gap != 0) begin
          snk_gap--;
          out_ch.ready <= 1'b0;
        end else begin
          out_ch.ready <= 1'b1;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg.valid && cfg.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  initial begin
    logic [VAL_W-1:0] period_val;
    logic [VAL_W-1:0] scale_val;
    int               order_val;

    rst                 = 1'b1;
    in_ch.valid         = 1'b0;
    in_ch.channel_index = '0;
    in_ch.sample_value  = '0;
    in_ch.start_run     = 1'b0;
    out_ch.ready        = 1'b0;
    cfg.valid           = 1'b0;
    cfg.index           = CFG_DIFF_ORDER;
    cfg.data            = '0;
    order_now           = '0;
    period_now          = '0;
    scale_now           = SCALE_RESET;
    foreach (level_mem[i, k]) level_mem[i][k] = '0;
    foreach (warm_cnt[i]) warm_cnt[i] = 0;
    mismatch_count      = 0;
    results_seen        = 0;
    long_hold_done      = 1'b0;
    quiet_cycles        = 0;
    src_idle_pct        = 15;
    snk_idle_pct        = 15;

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // pass-through at the reset settings, sample extremes on edge channels
    push_sample(0, SAMPLE_MAX, 1'b1);
    push_sample(CHANNELS - 1, SAMPLE_MIN, 1'b0);
    push_sample(1, 0, 1'b0);
    push_sample(2, -1, 1'b0);
    wait_drained();

    // first order with unwrap: both wrap corrections, negative remainders
    write_reg(CFG_DIFF_ORDER, 1);
    write_reg(CFG_UNWRAP_PERIOD, 1000);
    write_reg(CFG_SCALE, SCALE_RESET);
    push_sample(3, 0, 1'b1);
    push_sample(3, 900, 1'b0);
    push_sample(3, 100, 1'b0);
    push_sample(3, -700, 1'b0);
    push_sample(3, 400, 1'b0);
    wait_drained();

    // max order, full scale: warm-up zeros then saturated differences
    write_reg(CFG_DIFF_ORDER, MAX_ORDER);
    write_reg(CFG_UNWRAP_PERIOD, 0);
    write_reg(CFG_SCALE, 32'hFFFF_FFFF);
    push_sample(10, SAMPLE_MAX, 1'b1);
    for (int i = 0; i < 9; i++) push_sample(10, (i % 2) ? SAMPLE_MAX : SAMPLE_MIN, 1'b0);
    wait_drained();

    // order beyond max, zero scale, largest period
    write_reg(CFG_DIFF_ORDER, 15);
    write_reg(CFG_UNWRAP_PERIOD, SAMPLE_MAX);
    write_reg(CFG_SCALE, 0);
    push_sample(10, -5, 1'b0);
    push_sample(10, 77, 1'b0);
    push_sample(11, SAMPLE_MIN, 1'b0);

    for (int p = 0; p < 10; p++) begin
      wait_drained();
      src_idle_pct = (p % 3 == 1) ? 0 : $urandom_range(5, 30);
      snk_idle_pct = (p % 3 == 2) ? 0 : $urandom_range(5, 30);
      if (p == 9) begin
        src_idle_pct = 0;
        snk_idle_pct = 0;
      end
      if (p == 0) order_val = 0;
      else if (p == 1) order_val = MAX_ORDER;
      else if (p == 5) order_val = $urandom_range(MAX_ORDER + 1, 15);
      else order_val = $urandom_range(0, MAX_ORDER);
      case ($urandom_range(0, 5))
        0, 1:    period_val = 0;
        2:       period_val = $urandom_range(1, 64);
        3:       period_val = $urandom_range(65, SAMPLE_MAX);
        4:       period_val = SAMPLE_MAX;
        default: period_val = $urandom_range(1, 3);
      endcase
      case ($urandom_range(0, 5))
        0, 1:    scale_val = SCALE_RESET;
        2:       scale_val = $urandom_range(0, 131072);
        3:       scale_val = 32'hFFFF_FFFF;
        4:       scale_val = $urandom;
        default: scale_val = 0;
      endcase
      write_reg(CFG_DIFF_ORDER, order_val);
      write_reg(CFG_UNWRAP_PERIOD, period_val);
      write_reg(CFG_SCALE, scale_val);
      queue_random_run(90);
      queue_random_run(100);
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && diff_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
